// ===== design/qsl_pkg.sv =====
// Shared constants and control types for the quicksort batch sorter.
package qsl_pkg;

   localparam int STORE_DEPTH_DEF = 64;
   localparam int VALUE_WIDTH_DEF = 32;

   // Value store port controls
   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } ram_ctl_type;

   // Range stack controls
   typedef struct packed {
      logic push;
      logic pop;
   } stack_op_type;

   // Range stack status
   typedef struct packed {
      logic empty;
      logic full;
   } stack_stat_type;

endpackage

// ===== design/qsl_req_if.sv =====
// Request channel: one value of the batch per request.
interface qsl_req_if
   import qsl_pkg::*;
#(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
);
   logic                   valid;
   logic                   ready;
   logic [VALUE_WIDTH-1:0] element_value;
   logic                   last_element;

   modport source (output valid, output element_value, output last_element, input ready);
   modport sink   (input valid, input element_value, input last_element, output ready);
endinterface

// ===== design/qsl_rsp_if.sv =====
// Response channel: sorted values of a batch.
interface qsl_rsp_if
   import qsl_pkg::*;
#(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
);
   logic                   valid;
   logic                   ready;
   logic [VALUE_WIDTH-1:0] sorted_value;
   logic                   last_result;
   logic                   values_dropped;

   modport source (output valid, output sorted_value, output last_result,
                   output values_dropped, input ready);
   modport sink   (input valid, input sorted_value, input last_result,
                   input values_dropped, output ready);
endinterface

// ===== design/quicksort_lomuto_sorter_core.sv =====
// Batch sorter: Lomuto quicksort over a value memory, range stack instead of recursion.
// Load: one value per cycle while idle; the request flagged last starts the sort.
// Sort: pop a range, fetch its last entry as pivot, then read and compare each entry;
//   a swap needs two writes on the single write port, as does the final pivot exchange.
// Output: each sorted value is a memory read, then the output register load, which waits
//   while a response is held; the next value is read only after the previous one is loaded.
// Reset clears the control state only; memory contents are undefined, no clearing pass.
module quicksort_lomuto_sorter_core
   import qsl_pkg::*;
#(
   parameter int STORE_DEPTH = STORE_DEPTH_DEF,
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
   input logic       clock,
   input logic       reset,
   qsl_req_if.sink   req_ch,
   qsl_rsp_if.source rsp_ch
);

   localparam int IDX_W = $clog2(STORE_DEPTH);
   localparam int CNT_W = $clog2(STORE_DEPTH + 1);

   typedef enum logic [11:0] {
      ST_LOAD     = 12'b0000_0000_0001,
      ST_POP      = 12'b0000_0000_0010,
      ST_RANGE    = 12'b0000_0000_0100,
      ST_PIVOT    = 12'b0000_0000_1000,
      ST_SCAN_RD  = 12'b0000_0001_0000,
      ST_SCAN_CMP = 12'b0000_0010_0000,
      ST_SWAP     = 12'b0000_0100_0000,
      ST_FIN_RD   = 12'b0000_1000_0000,
      ST_FIN_WR1  = 12'b0001_0000_0000,
      ST_FIN_WR2  = 12'b0010_0000_0000,
      ST_EMIT_RD  = 12'b0100_0000_0000,
      ST_EMIT_LD  = 12'b1000_0000_0000
   } state_type;

   state_type              state_ff, state_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic                   overflow_ff, overflow_in;
   logic [IDX_W-1:0]       lo_ff, lo_in;
   logic [IDX_W-1:0]       hi_ff, hi_in;
   logic [IDX_W-1:0]       i_ff, i_in;
   logic [IDX_W-1:0]       place_ff, place_in;
   logic [IDX_W-1:0]       k_ff, k_in;
   logic [VALUE_WIDTH-1:0] pivot_ff, pivot_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [VALUE_WIDTH-1:0] rsp_value_ff, rsp_value_in;
   logic                   rsp_last_ff, rsp_last_in;
   logic                   rsp_drop_ff, rsp_drop_in;

   ram_ctl_type            ram_ctl;
   logic [IDX_W-1:0]       wr_addr, rd_addr_a, rd_addr_b;
   logic [VALUE_WIDTH-1:0] wr_data, rd_data_a, rd_data_b;

   stack_op_type           stk_op;
   stack_stat_type         stk_stat;
   logic [IDX_W-1:0]       push_lo, push_hi, pop_lo, pop_hi;

   logic                   req_take;
   logic                   out_free;
   logic                   less;
   logic                   scan_done;
   logic [CNT_W-1:0]       count_next;
   logic [IDX_W:0]         place_x, lo_x, hi_x, i_x;

   qsl_value_ram #(
      .DEPTH (STORE_DEPTH),
      .WIDTH (VALUE_WIDTH)
   ) u_ram (
      .clock     (clock),
      .ctl       (ram_ctl),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   qsl_range_stack #(
      .SLOTS (STORE_DEPTH),
      .IDX_W (IDX_W)
   ) u_stack (
      .clock   (clock),
      .reset   (reset),
      .op      (stk_op),
      .push_lo (push_lo),
      .push_hi (push_hi),
      .pop_lo  (pop_lo),
      .pop_hi  (pop_hi),
      .stat    (stk_stat)
   );

   assign req_ch.ready = (state_ff == ST_LOAD);
   assign req_take     = req_ch.valid && req_ch.ready;
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;

   assign place_x   = {1'b0, place_ff};
   assign lo_x      = {1'b0, lo_ff};
   assign hi_x      = {1'b0, hi_ff};
   assign i_x       = {1'b0, i_ff};
   assign less      = $signed(rd_data_a) < $signed(pivot_ff);
   assign scan_done = (i_x + (IDX_W+1)'(1)) == hi_x;

   always_comb begin
      count_next   = count_ff;
      state_in     = state_ff;
      count_in     = count_ff;
      overflow_in  = overflow_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      i_in         = i_ff;
      place_in     = place_ff;
      k_in         = k_ff;
      pivot_in     = pivot_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_drop_in  = rsp_drop_ff;
      ram_ctl      = '0;
      wr_addr      = count_ff[IDX_W-1:0];
      wr_data      = req_ch.element_value;
      rd_addr_a    = i_ff;
      rd_addr_b    = place_ff;
      stk_op       = '0;
      push_lo      = '0;
      push_hi      = count_next[IDX_W-1:0];

      case (state_ff)
         ST_LOAD: begin
            if (req_take) begin
               if (count_ff < CNT_W'(STORE_DEPTH)) begin
                  ram_ctl.wr_en = 1'b1;
                  count_next    = count_ff + CNT_W'(1);
               end else begin
                  overflow_in = 1'b1;
               end
               count_in = count_next;
               // whole batch pushed as the first range
               push_hi  = IDX_W'(count_next - CNT_W'(1));
               if (req_ch.last_element) begin
                  k_in = '0;
                  if (count_next < CNT_W'(2)) begin
                     state_in = ST_EMIT_RD;
                  end else begin
                     stk_op.push = 1'b1;
                     state_in    = ST_POP;
                  end
               end
            end
         end
         ST_POP: begin
            if (stk_stat.empty) begin
               state_in = ST_EMIT_RD;
            end else begin
               stk_op.pop = 1'b1;
               state_in   = ST_RANGE;
            end
         end
         ST_RANGE: begin
            lo_in          = pop_lo;
            hi_in          = pop_hi;
            i_in           = pop_lo;
            place_in       = pop_lo;
            rd_addr_a      = pop_hi;
            ram_ctl.rd_en  = 1'b1;
            state_in       = ST_PIVOT;
         end
         ST_PIVOT: begin
            pivot_in = rd_data_a;
            state_in = ST_SCAN_RD;
         end
         ST_SCAN_RD: begin
            ram_ctl.rd_en = 1'b1;
            state_in      = ST_SCAN_CMP;
         end
         ST_SCAN_CMP: begin
            if (less) begin
               ram_ctl.wr_en = 1'b1;
               wr_addr       = place_ff;
               wr_data       = rd_data_a;
               place_in      = place_ff + IDX_W'(1);
               state_in      = ST_SWAP;
            end else begin
               i_in     = i_ff + IDX_W'(1);
               state_in = scan_done ? ST_FIN_RD : ST_SCAN_RD;
            end
         end
         ST_SWAP: begin
            ram_ctl.wr_en = 1'b1;
            wr_addr       = i_ff;
            wr_data       = rd_data_b;
            i_in          = i_ff + IDX_W'(1);
            state_in      = scan_done ? ST_FIN_RD : ST_SCAN_RD;
         end
         ST_FIN_RD: begin
            rd_addr_a     = place_ff;
            ram_ctl.rd_en = 1'b1;
            state_in      = ST_FIN_WR1;
         end
         ST_FIN_WR1: begin
            // pivot into its final place; left part pushed if two or more long
            ram_ctl.wr_en = 1'b1;
            wr_addr       = place_ff;
            wr_data       = pivot_ff;
            push_lo       = lo_ff;
            push_hi       = place_ff - IDX_W'(1);
            stk_op.push   = place_x > (lo_x + (IDX_W+1)'(1));
            state_in      = ST_FIN_WR2;
         end
         ST_FIN_WR2: begin
            ram_ctl.wr_en = 1'b1;
            wr_addr       = hi_ff;
            wr_data       = rd_data_a;
            push_lo       = place_ff + IDX_W'(1);
            push_hi       = hi_ff;
            stk_op.push   = (place_x + (IDX_W+1)'(1)) < hi_x;
            state_in      = ST_POP;
         end
         ST_EMIT_RD: begin
            rd_addr_a     = k_ff;
            ram_ctl.rd_en = 1'b1;
            state_in      = ST_EMIT_LD;
         end
         ST_EMIT_LD: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = rd_data_a;
               rsp_drop_in  = overflow_ff;
               rsp_last_in  = ({1'b0, k_ff} + (IDX_W+1)'(1)) == (IDX_W+1)'(count_ff);
               k_in         = k_ff + IDX_W'(1);
               if (rsp_last_in) begin
                  count_in    = '0;
                  overflow_in = 1'b0;
                  state_in    = ST_LOAD;
               end else begin
                  state_in = ST_EMIT_RD;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         overflow_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         overflow_ff  <= overflow_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      i_ff         <= i_in;
      place_ff     <= place_in;
      k_ff         <= k_in;
      pivot_ff     <= pivot_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_drop_ff  <= rsp_drop_in;
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.sorted_value   = rsp_value_ff;
   assign rsp_ch.last_result    = rsp_last_ff;
   assign rsp_ch.values_dropped = rsp_drop_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(STORE_DEPTH))
      else $error("stored count beyond store depth");

   a_popped_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RANGE |-> (pop_lo < pop_hi) && ({1'b0, pop_hi} < (IDX_W+1)'(count_ff)))
      else $error("popped range empty or outside the batch");

   a_scan_order: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN_RD |-> (lo_ff <= place_ff) && (place_ff <= i_ff) && (i_ff < hi_ff))
      else $error("partition indexes out of order");

   a_stack_drained: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT_RD |-> stk_stat.empty)
      else $error("emitting with ranges still pending");

   a_batch_closed: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT_LD && out_free && rsp_last_in) |=>
         (state_ff == ST_LOAD && count_ff == '0 && !overflow_ff))
      else $error("batch state not cleared after final response");

endmodule

// ===== design/qsl_value_ram.sv =====
// Value store: one write port, two registered read ports.
module qsl_value_ram
   import qsl_pkg::*;
#(
   parameter int DEPTH = STORE_DEPTH_DEF,
   parameter int WIDTH = VALUE_WIDTH_DEF,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic              clock,
   input  ram_ctl_type       ctl,
   input  logic [AW-1:0]     wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [AW-1:0]     rd_addr_a,
   input  logic [AW-1:0]     rd_addr_b,
   output logic [WIDTH-1:0]  rd_data_a,
   output logic [WIDTH-1:0]  rd_data_b
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   // read data holds while rd_en is low
   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_a_ff <= store_ff[rd_addr_a];
         rd_b_ff <= store_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

// ===== design/qsl_range_stack.sv =====
// Stack of pending index ranges, kept in a small synchronous memory.
module qsl_range_stack
   import qsl_pkg::*;
#(
   parameter int SLOTS = STORE_DEPTH_DEF,
   parameter int IDX_W = $clog2(STORE_DEPTH_DEF),
   localparam int SW   = $clog2(SLOTS),
   localparam int PW   = $clog2(SLOTS + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  stack_op_type     op,
   input  logic [IDX_W-1:0] push_lo,
   input  logic [IDX_W-1:0] push_hi,
   output logic [IDX_W-1:0] pop_lo,
   output logic [IDX_W-1:0] pop_hi,
   output stack_stat_type   stat
);

   logic [2*IDX_W-1:0] slot_ff [SLOTS];
   logic [2*IDX_W-1:0] top_ff;
   logic [PW-1:0]      ptr_ff;
   logic [PW-1:0]      ptr_in;
   logic [PW-1:0]      ptr_dec;
   logic               do_push;
   logic               do_pop;

   assign ptr_dec   = ptr_ff - PW'(1);
   assign stat.empty = (ptr_ff == '0);
   assign stat.full  = (ptr_ff == PW'(SLOTS));
   assign do_push   = op.push && !stat.full;
   assign do_pop    = op.pop && !stat.empty;

   always_comb begin
      ptr_in = ptr_ff;
      if (do_push) begin
         ptr_in = ptr_ff + PW'(1);
      end else if (do_pop) begin
         ptr_in = ptr_dec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff <= '0;
      end else begin
         ptr_ff <= ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[ptr_ff[SW-1:0]] <= {push_lo, push_hi};
      end
   end

   always_ff @(posedge clock) begin
      if (do_pop) begin
         top_ff <= slot_ff[ptr_dec[SW-1:0]];
      end
   end

   assign pop_lo = top_ff[2*IDX_W-1:IDX_W];
   assign pop_hi = top_ff[IDX_W-1:0];

endmodule
